// ----- rtl/core/mmmc_pkg.sv -----
// shared types and constants of the min median mean collapse unit
`default_nettype none

package mmmc_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int SCORE_W     = 32;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SCORE_W + $clog2(MAX_SAMPLES);
  localparam int STEP_W      = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;
    logic               shift;
    logic [SCORE_W-1:0] v;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/mmmc_cell.sv -----
// one cell of the sorting chain: holds one sample, inserts or shifts toward cell 0
`default_nettype none

module mmmc_cell
  import mmmc_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic               occupied,
  input  wire logic               prev_gt,
  input  wire logic [SCORE_W-1:0] prev_val,
  input  wire logic [SCORE_W-1:0] next_val,
  output logic                    gt,
  output logic [SCORE_W-1:0]      val
);

  logic [SCORE_W-1:0] val_r;
  logic [SCORE_W-1:0] val_nxt;

  // an empty cell acts as plus infinity
  assign gt  = !occupied || ($signed(val_r) > $signed(ctl.v));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.ins && gt) begin
      val_nxt = prev_gt ? prev_val : ctl.v;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mmmc_divider.sv -----
// restoring divider, one quotient bit a cycle while step is high, magnitude of the sum by the count
`default_nettype none

module mmmc_divider
  import mmmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic      [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0] d_r;
  logic [SUM_W-1:0] d_nxt;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] rem_nxt;
  logic [CNT_W:0]   rem_sh;
  logic             qbit;

  always_comb begin
    rem_sh  = {rem_r, d_r[SUM_W-1]};
    qbit    = (rem_sh >= {1'b0, divisor});
    d_nxt   = d_r;
    rem_nxt = rem_r;
    if (load) begin
      d_nxt   = dividend;
      rem_nxt = '0;
    end else if (step) begin
      d_nxt   = {d_r[SUM_W-2:0], qbit};
      rem_nxt = qbit ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = d_r;

endmodule

`default_nettype wire

// ----- rtl/core/min_median_mean_collapse_unit.sv -----
// top level: sorting chain, running sum, serial mean divider and result register
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata[31:0] score, tlast last
// out_    | out | out_tvalid/tready  | tdata[31:0] robust_score, tuser overflow
//
// a sample is written into the chain as it is accepted; samples of a run go back to back
// after the marked sample: a load state, the divider states and a result state follow;
// the chain shifts out the median meanwhile
// in_tready is low from the marked sample until the result is registered
// the result waits in the output register while the next run loads
// rst_n is synchronous and active low and clears control state only
`default_nettype none

module min_median_mean_collapse_unit
  import mmmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] score
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] robust_score
  output logic             out_tuser   // [0] overflow
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               drop_r, drop_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               neg_r, neg_nxt;
  logic               ovf_r, ovf_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SCORE_W-1:0] lo_r, lo_nxt;
  logic [SCORE_W-1:0] hi_r, hi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               in_acc;
  logic               has_room;
  logic               ins;
  logic               div_load;
  logic               div_step;
  logic               finish;
  logic               out_free;
  cell_ctl_t          ctl;

  logic [SCORE_W-1:0] cell_val [MAX_SAMPLES];
  logic               cell_gt  [MAX_SAMPLES];
  logic [SUM_W-1:0]   dividend;
  logic [SUM_W-1:0]   quotient;
  logic [STEP_W-1:0]  half;
  logic [SCORE_W:0]   pair_sum;
  logic [SCORE_W-1:0] median;
  logic [SCORE_W-1:0] mean;
  logic [SUM_W-1:0]   mean_full;

  assign in_acc   = in_tvalid && in_tready;
  assign has_room = (count_r < CNT_W'(MAX_SAMPLES));
  assign ins      = in_acc && has_room;
  assign out_free = !out_valid_r || out_tready;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && in_tlast) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (step_r == STEP_W'(SUM_W - 1)) state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    div_load  = 1'b0;
    div_step  = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_LOAD:   div_load  = 1'b1;
      ST_DIVIDE: div_step  = 1'b1;
      ST_RESULT: finish    = out_free;
      default:   in_tready = 1'b0;
    endcase
  end

  assign ctl = '{ins: ins, shift: div_step, v: in_tdata};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_chain
      logic               p_gt;
      logic [SCORE_W-1:0] p_val;
      logic [SCORE_W-1:0] n_val;
      if (gi == 0) begin : g_first
        assign p_gt  = 1'b0;
        assign p_val = in_tdata;
      end else begin : g_mid
        assign p_gt  = cell_gt[gi-1];
        assign p_val = cell_val[gi-1];
      end
      if (gi == MAX_SAMPLES - 1) begin : g_end
        assign n_val = cell_val[gi];
      end else begin : g_inner
        assign n_val = cell_val[gi+1];
      end
      mmmc_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .occupied (count_r > CNT_W'(gi)),
        .prev_gt  (p_gt),
        .prev_val (p_val),
        .next_val (n_val),
        .gt       (cell_gt[gi]),
        .val      (cell_val[gi])
      );
    end
  endgenerate

  // floor division of a negative sum: -ceil(|s| / n), and |s| + n - 1 = ~s + n
  assign dividend = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(count_r)) : sum_r;

  mmmc_divider u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .dividend (dividend),
    .divisor  (n_r),
    .quotient (quotient)
  );

  assign half      = STEP_W'(n_r >> 1);
  assign pair_sum  = {lo_r[SCORE_W-1], lo_r} + {hi_r[SCORE_W-1], hi_r};
  assign median    = n_r[0] ? hi_r : pair_sum[SCORE_W:1];
  assign mean_full = neg_r ? (~quotient + SUM_W'(1)) : quotient;
  assign mean      = mean_full[SCORE_W-1:0];

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_score_nxt = out_score_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (ins) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + {{(SUM_W - SCORE_W){in_tdata[SCORE_W-1]}}, in_tdata};
    end else if (in_acc) begin
      drop_nxt = 1'b1;
    end

    if (div_load) begin
      n_nxt     = count_r;
      neg_nxt   = sum_r[SUM_W-1];
      ovf_nxt   = drop_r;
      step_nxt  = '0;
      count_nxt = '0;
      sum_nxt   = '0;
      drop_nxt  = 1'b0;
    end

    // cell 0 holds the element of rank step_r while the chain drains
    if (div_step) begin
      step_nxt = step_r + STEP_W'(1);
      if (step_r == half) hi_nxt = cell_val[0];
      if (step_r + STEP_W'(1) == half) lo_nxt = cell_val[0];
    end

    if (finish) begin
      out_valid_nxt = 1'b1;
      out_score_nxt = ($signed(mean) < $signed(median)) ? mean : median;
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    neg_r       <= neg_nxt;
    ovf_r       <= ovf_nxt;
    step_r      <= step_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_score_r <= out_score_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_score_r;
  assign out_tuser  = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_last_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> state_r == ST_LOAD)
    else $error("marked item did not start the result sequence");

  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not registered at end of run");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> count_r == '0 && sum_r == '0 && !drop_r)
    else $error("run state not cleared after last item");

endmodule

`default_nettype wire
